// File: design/dual_source_failover_selector_core_assert.svh
// Assertion macros used by the selector control module (dsfs_ctrl).
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DUAL_SOURCE_FAILOVER_SELECTOR_CORE_ASSERT_SVH
`define DUAL_SOURCE_FAILOVER_SELECTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSFS_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("selector assertion failed");
`define DSFS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("selector assertion failed");
`else
`define DSFS_ASSERT_SAME(lbl, a, b)
`define DSFS_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: design/dsfs_pkg.sv
`timescale 1ns / 1ps
package dsfs_pkg;
    localparam int SLOTS   = 8;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int FILL_W  = $clog2(SLOTS + 1);
    localparam int GEN_W   = 32;
    localparam int TIME_W  = 40;
    localparam int MS_W    = 20;
    localparam logic [TIME_W:0] WINDOW_MS = 41'd60000;

    localparam logic [3:0] M_START        = 4'd0;
    localparam logic [3:0] M_HEALTHY      = 4'd3;
    localparam logic [3:0] M_PREPARE_FAIL = 4'd4;
    localparam logic [3:0] M_UNSUPPORTED  = 4'd5;
    localparam logic [3:0] M_REMOVED      = 4'd7;
    localparam logic [3:0] M_SRC_UNAVAIL  = 4'd8;
    localparam logic [3:0] M_TIMEOUT      = 4'd9;
    localparam logic [3:0] M_SECURE       = 4'd10;
    localparam logic [3:0] M_DESK_AVAIL   = 4'd11;
    localparam logic [3:0] M_DISPLAY_CHG  = 4'd12;
    localparam logic [3:0] M_FORCE        = 4'd13;
    localparam logic [3:0] M_RETIRE_START = 4'd14;
    localparam logic [3:0] M_RETIRE_DONE  = 4'd15;
    localparam logic [3:0] FAIL_BIAS      = 4'd3;

    localparam logic [2:0] A_KEEP     = 3'd0;
    localparam logic [2:0] A_START    = 3'd1;
    localparam logic [2:0] A_COMMIT   = 3'd2;
    localparam logic [2:0] A_DISCARD  = 3'd3;
    localparam logic [2:0] A_PAUSE    = 3'd4;
    localparam logic [2:0] A_TERMINAL = 3'd5;

    localparam logic [2:0] F_NONE        = 3'd0;
    localparam logic [2:0] F_UNSUPPORTED = 3'd2;
    localparam logic [2:0] F_SRC_UNAVAIL = 3'd5;
    localparam logic [2:0] F_TIMEOUT     = 3'd6;
    localparam logic [2:0] F_SECURE      = 3'd7;

    localparam logic [1:0] R_WINDOW   = 2'd0;
    localparam logic [1:0] R_LIMIT    = 2'd1;
    localparam logic [1:0] R_INTERVAL = 2'd2;
    localparam logic [1:0] R_DEADLINE = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_LOAD, CMD_DECIDE, CMD_CHECK, CMD_PRUNE, CMD_SELECT, CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic begin_req;
        logic check_go;
        logic prune_more;
    } status_t;
endpackage

// File: design/dsfs_ctrl.sv
`timescale 1ns / 1ps
`include "dual_source_failover_selector_core_assert.svh"
module dsfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dsfs_pkg::status_t status,
    output dsfs_pkg::cmd_t    cmd
);
    typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_CHECK, S_PRUNE, S_SELECT, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = dsfs_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = dsfs_pkg::CMD_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd        = dsfs_pkg::CMD_DECIDE;
                state_next = status.begin_req ? S_CHECK : S_OUT;
            end
            S_CHECK:
            begin
                cmd        = dsfs_pkg::CMD_CHECK;
                state_next = status.check_go ? S_PRUNE : S_OUT;
            end
            S_PRUNE:
            begin
                // drop expired attempts one per cycle
                cmd = dsfs_pkg::CMD_PRUNE;
                if (!status.prune_more)
                    state_next = S_SELECT;
            end
            S_SELECT:
            begin
                cmd        = dsfs_pkg::CMD_SELECT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = dsfs_pkg::CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `DSFS_ASSERT_NEXT(a_accept_decides, in_valid && in_ready, state_reg == S_DECIDE)
    `DSFS_ASSERT_NEXT(a_select_outputs, state_reg == S_SELECT, state_reg == S_OUT)
    `DSFS_ASSERT_NEXT(a_out_loads_valid, cmd == dsfs_pkg::CMD_OUT, out_valid)
    `DSFS_ASSERT_SAME(a_prune_only_busy, state_reg == S_PRUNE, !in_ready)
endmodule

// File: design/dsfs_datapath.sv
`timescale 1ns / 1ps
module dsfs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsfs_pkg::cmd_t                cmd,
    output dsfs_pkg::status_t             status,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [dsfs_pkg::MS_W-1:0]     cfg_data,
    input  logic [3:0]                    mode,
    input  logic [dsfs_pkg::TIME_W-1:0]   now_ms,
    input  logic                          origin_kind,
    input  logic [dsfs_pkg::GEN_W-1:0]    origin_generation,
    input  logic                          force_valid,
    input  logic                          force_kind,
    output logic [2:0]                    action,
    output logic                          cand_valid,
    output logic                          cand_kind,
    output logic [dsfs_pkg::GEN_W-1:0]    cand_gen,
    output logic                          act_valid,
    output logic                          act_kind,
    output logic [dsfs_pkg::GEN_W-1:0]    act_gen,
    output logic                          act_healthy,
    output logic                          is_paused,
    output logic                          is_terminal,
    output logic                          retire_busy,
    output logic [2:0]                    fail_code
);
    localparam int TW = dsfs_pkg::TIME_W;
    localparam int GW = dsfs_pkg::GEN_W;
    localparam logic [dsfs_pkg::FILL_W-1:0] FILL_ONE = 1;

    // configuration
    logic                   win_reg;
    logic [7:0]             limit_reg;
    logic [dsfs_pkg::MS_W-1:0] interval_reg, deadline_reg;

    // latched event
    logic [3:0]    m_reg;
    logic [TW-1:0] now_reg;
    logic          ok_reg, fv_reg, fk_reg;
    logic [GW-1:0] og_reg;

    // selector state
    logic [TW-1:0] last_time_reg, last_time_next;
    logic [TW-1:0] times_reg [dsfs_pkg::SLOTS];
    logic [TW-1:0] last_att_reg;
    logic [dsfs_pkg::FILL_W-1:0] fill_reg;
    logic pend_reg, pend_next, paused_reg, paused_next, term_reg, term_next;
    logic retire_reg, retire_next, healthy_reg, healthy_next;
    logic avail_a_reg, avail_a_next, avail_b_reg, avail_b_next;
    logic act_v_reg, act_v_next, act_k_reg, act_k_next;
    logic [GW-1:0] act_g_reg, act_g_next;
    logic cand_v_reg, cand_v_next, cand_k_reg, cand_k_next;
    logic [GW-1:0] cand_g_reg, cand_g_next;
    logic [TW-1:0] cand_start_reg, cand_start_next;
    logic [7:0] streak_reg, streak_next;
    logic [2:0] lf_reg, lf_next;
    logic try_v_reg, try_v_next, try_k_reg, try_k_next;
    logic forced_v_reg, forced_v_next, forced_k_reg, forced_k_next;
    logic [GW-1:0] gen_reg, gen_next;
    logic [2:0] code_reg, code_next;
    logic begin_req;
    logic check_go;
    logic do_record;

    logic [2:0] out_action_reg, out_lf_reg;
    logic out_cv_reg, out_ck_reg, out_av_reg, out_ak_reg;
    logic out_h_reg, out_p_reg, out_t_reg, out_r_reg;
    logic [GW-1:0] out_cg_reg, out_ag_reg;

    logic oc, oa, is_fail, expired, prune_more, sel, sel_ok, use_a, use_b;
    logic [7:0] streak_bump;
    logic [2:0] mode_fail;

    assign oc = cand_v_reg && (cand_k_reg == ok_reg) && (cand_g_reg == og_reg);
    assign oa = act_v_reg && (act_k_reg == ok_reg) && (act_g_reg == og_reg);
    assign is_fail = (m_reg >= dsfs_pkg::M_PREPARE_FAIL) && (m_reg <= dsfs_pkg::M_TIMEOUT);
    assign mode_fail = 3'(m_reg - dsfs_pkg::FAIL_BIAS);
    assign streak_bump = (streak_reg == 8'hFF) ? streak_reg : streak_reg + 8'd1;
    assign expired = cand_v_reg &&
        ({1'b0, now_reg} >= ({1'b0, cand_start_reg} + (TW+1)'(deadline_reg)));
    assign prune_more = (fill_reg != '0) &&
        ({1'b0, now_reg} >= ({1'b0, times_reg[0]} + dsfs_pkg::WINDOW_MS));
    assign use_a = avail_a_reg;
    assign use_b = !win_reg && avail_b_reg;

    always_comb
    begin
        logic hw, pw;
        sel = (lf_reg != dsfs_pkg::F_NONE && try_v_reg) ? !try_k_reg :
              (act_v_reg ? act_k_reg : 1'b0);
        if (forced_v_reg)
            sel = forced_k_reg;
        else if (!(sel ? use_b : use_a))
            sel = !sel;
        sel_ok = sel ? use_b : use_a;

        last_time_next = last_time_reg;  pend_next = pend_reg;  paused_next = paused_reg;
        term_next = term_reg;  retire_next = retire_reg;  healthy_next = healthy_reg;
        avail_a_next = avail_a_reg;  avail_b_next = avail_b_reg;
        act_v_next = act_v_reg;  act_k_next = act_k_reg;  act_g_next = act_g_reg;
        cand_v_next = cand_v_reg;  cand_k_next = cand_k_reg;  cand_g_next = cand_g_reg;
        cand_start_next = cand_start_reg;  streak_next = streak_reg;  lf_next = lf_reg;
        try_v_next = try_v_reg;  try_k_next = try_k_reg;
        forced_v_next = forced_v_reg;  forced_k_next = forced_k_reg;
        gen_next = gen_reg;  code_next = code_reg;
        begin_req = 1'b0;  check_go = 1'b0;  do_record = 1'b0;
        hw = healthy_reg;  pw = pend_reg;

        case (cmd)
            dsfs_pkg::CMD_DECIDE:
            begin
                code_next = dsfs_pkg::A_KEEP;
                if (now_reg >= last_time_reg)
                begin
                    last_time_next = now_reg;
                    case (m_reg)
                        dsfs_pkg::M_RETIRE_START: retire_next = 1'b1;
                        dsfs_pkg::M_RETIRE_DONE:  retire_next = 1'b0;
                        dsfs_pkg::M_SECURE:
                        begin
                            if (og_reg != '0 && !oa && !oc)
                                code_next = dsfs_pkg::A_KEEP;
                            else if (oc && healthy_reg)
                            begin
                                cand_v_next = 1'b0;  pend_next = 1'b0;
                                streak_next = streak_bump;  lf_next = dsfs_pkg::F_SECURE;
                                code_next = dsfs_pkg::A_DISCARD;
                            end
                            else if (!paused_reg)
                            begin
                                paused_next = 1'b1;  healthy_next = 1'b0;
                                cand_v_next = 1'b0;  pend_next = 1'b0;
                                code_next = dsfs_pkg::A_PAUSE;
                            end
                        end
                        dsfs_pkg::M_DESK_AVAIL:
                        begin
                            if (paused_reg)
                            begin
                                paused_next = 1'b0;  term_next = 1'b0;
                                pend_next = 1'b1;  streak_next = '0;  begin_req = 1'b1;
                            end
                        end
                        dsfs_pkg::M_FORCE:
                        begin
                            forced_v_next = fv_reg;  forced_k_next = fk_reg;
                            term_next = 1'b0;  streak_next = '0;
                            if (paused_reg)
                                code_next = dsfs_pkg::A_KEEP;
                            else if (cand_v_reg)
                            begin
                                if (!(fv_reg && fk_reg == cand_k_reg))
                                begin
                                    cand_v_next = 1'b0;
                                    pend_next = !healthy_reg ||
                                        (fv_reg && !(act_v_reg && fk_reg == act_k_reg));
                                    code_next = dsfs_pkg::A_DISCARD;
                                end
                            end
                            else if (healthy_reg &&
                                     (!fv_reg || (act_v_reg && fk_reg == act_k_reg)))
                                pend_next = 1'b0;
                            else
                            begin
                                pend_next = 1'b1;  begin_req = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (paused_reg)
                                code_next = dsfs_pkg::A_KEEP;
                            else if (m_reg == dsfs_pkg::M_SRC_UNAVAIL && og_reg == '0)
                            begin
                                healthy_next = 1'b0;  term_next = 1'b1;  pend_next = 1'b0;
                                cand_v_next = 1'b0;  lf_next = dsfs_pkg::F_SRC_UNAVAIL;
                                code_next = term_reg ? dsfs_pkg::A_KEEP : dsfs_pkg::A_TERMINAL;
                            end
                            else if (m_reg == dsfs_pkg::M_DISPLAY_CHG)
                            begin
                                term_next = 1'b0;  streak_next = '0;
                                avail_a_next = 1'b1;  avail_b_next = 1'b1;
                                if (!(healthy_reg || cand_v_reg))
                                begin
                                    pend_next = 1'b1;  begin_req = 1'b1;
                                end
                            end
                            else if (!term_reg)
                            begin
                                if (m_reg == dsfs_pkg::M_START && !act_v_reg && !cand_v_reg)
                                    pw = 1'b1;
                                if (oa && is_fail)
                                begin
                                    hw = 1'b0;  lf_next = mode_fail;  pw = 1'b1;
                                end
                                healthy_next = hw;
                                if (oa && is_fail && (m_reg == dsfs_pkg::M_SRC_UNAVAIL ||
                                                      m_reg == dsfs_pkg::M_REMOVED))
                                begin
                                    term_next = 1'b1;  pend_next = 1'b0;
                                    code_next = dsfs_pkg::A_TERMINAL;
                                end
                                else if (expired || (oc && is_fail))
                                begin
                                    lf_next = expired ? dsfs_pkg::F_TIMEOUT : mode_fail;
                                    if (!expired && m_reg == dsfs_pkg::M_UNSUPPORTED)
                                    begin
                                        if (ok_reg)
                                            avail_b_next = 1'b0;
                                        else
                                            avail_a_next = 1'b0;
                                    end
                                    streak_next = streak_bump;
                                    cand_v_next = 1'b0;  pend_next = !hw;
                                    code_next = dsfs_pkg::A_DISCARD;
                                end
                                else if (oc && m_reg == dsfs_pkg::M_HEALTHY)
                                begin
                                    retire_next = act_v_reg;
                                    act_v_next = 1'b1;  act_k_next = cand_k_reg;
                                    act_g_next = cand_g_reg;  cand_v_next = 1'b0;
                                    healthy_next = 1'b1;  streak_next = '0;
                                    lf_next = dsfs_pkg::F_NONE;  pend_next = 1'b0;
                                    code_next = dsfs_pkg::A_COMMIT;
                                end
                                else
                                begin
                                    pend_next = pw;  begin_req = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            dsfs_pkg::CMD_CHECK:
            begin
                code_next = dsfs_pkg::A_KEEP;
                if (!(paused_reg || term_reg || retire_reg || cand_v_reg || !pend_reg))
                begin
                    if (streak_reg >= limit_reg)
                    begin
                        term_next = 1'b1;  pend_next = 1'b0;
                        code_next = dsfs_pkg::A_TERMINAL;
                    end
                    else
                        check_go = 1'b1;
                end
            end
            dsfs_pkg::CMD_SELECT:
            begin
                code_next = dsfs_pkg::A_KEEP;
                if (fill_reg < dsfs_pkg::FILL_W'(dsfs_pkg::SLOTS) &&
                    !(fill_reg != '0 && ({1'b0, now_reg} <
                      ({1'b0, last_att_reg} + (TW+1)'(interval_reg)))))
                begin
                    pend_next = 1'b0;
                    if (!sel_ok)
                    begin
                        lf_next = dsfs_pkg::F_UNSUPPORTED;
                        if (!healthy_reg)
                        begin
                            term_next = 1'b1;  code_next = dsfs_pkg::A_TERMINAL;
                        end
                    end
                    else
                    begin
                        cand_v_next = 1'b1;  cand_k_next = sel;  cand_g_next = gen_reg;
                        gen_next = gen_reg + GW'(1);
                        try_v_next = 1'b1;  try_k_next = sel;
                        cand_start_next = now_reg;  do_record = 1'b1;
                        code_next = dsfs_pkg::A_START;
                    end
                end
            end
            default: code_next = code_reg;
        endcase
    end

    assign status = '{begin_req: begin_req, check_go: check_go, prune_more: prune_more};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 1'b0;  limit_reg <= 8'd3;
            interval_reg <= 20'd1000;  deadline_reg <= 20'd5000;
            last_time_reg <= '0;  fill_reg <= '0;
            pend_reg <= 1'b0;  paused_reg <= 1'b0;  term_reg <= 1'b0;
            retire_reg <= 1'b0;  healthy_reg <= 1'b0;
            avail_a_reg <= 1'b1;  avail_b_reg <= 1'b1;
            act_v_reg <= 1'b0;  act_k_reg <= 1'b0;  act_g_reg <= '0;
            cand_v_reg <= 1'b0;  cand_k_reg <= 1'b0;  cand_g_reg <= '0;
            cand_start_reg <= '0;  streak_reg <= '0;  lf_reg <= dsfs_pkg::F_NONE;
            try_v_reg <= 1'b0;  try_k_reg <= 1'b0;
            forced_v_reg <= 1'b0;  forced_k_reg <= 1'b0;
            gen_reg <= GW'(1);  code_reg <= dsfs_pkg::A_KEEP;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dsfs_pkg::R_WINDOW:   win_reg <= cfg_data[0];
                    dsfs_pkg::R_LIMIT:    limit_reg <= cfg_data[7:0];
                    dsfs_pkg::R_INTERVAL: interval_reg <= cfg_data;
                    dsfs_pkg::R_DEADLINE: deadline_reg <= cfg_data;
                    default: win_reg <= win_reg;
                endcase
            end
            last_time_reg <= last_time_next;
            pend_reg <= pend_next;  paused_reg <= paused_next;  term_reg <= term_next;
            retire_reg <= retire_next;  healthy_reg <= healthy_next;
            avail_a_reg <= avail_a_next;  avail_b_reg <= avail_b_next;
            act_v_reg <= act_v_next;  act_k_reg <= act_k_next;  act_g_reg <= act_g_next;
            cand_v_reg <= cand_v_next;  cand_k_reg <= cand_k_next;
            cand_g_reg <= cand_g_next;  cand_start_reg <= cand_start_next;
            streak_reg <= streak_next;  lf_reg <= lf_next;
            try_v_reg <= try_v_next;  try_k_reg <= try_k_next;
            forced_v_reg <= forced_v_next;  forced_k_reg <= forced_k_next;
            gen_reg <= gen_next;  code_reg <= code_next;
            if (cmd == dsfs_pkg::CMD_PRUNE && prune_more)
                fill_reg <= fill_reg - FILL_ONE;
            else if (do_record)
                fill_reg <= fill_reg + FILL_ONE;
        end
    end

    // attempt window: oldest at entry 0, shift down on prune
    always_ff @(posedge clk)
    begin
        if (cmd == dsfs_pkg::CMD_LOAD)
        begin
            m_reg <= mode;  now_reg <= now_ms;  ok_reg <= origin_kind;
            og_reg <= origin_generation;  fv_reg <= force_valid;  fk_reg <= force_kind;
        end
        if (cmd == dsfs_pkg::CMD_PRUNE && prune_more)
        begin
            for (int i = 0; i < dsfs_pkg::SLOTS - 1; i++)
                times_reg[i] <= times_reg[i+1];
        end
        else if (do_record)
        begin
            times_reg[fill_reg[dsfs_pkg::IDX_W-1:0]] <= now_reg;
            last_att_reg <= now_reg;
        end
        if (cmd == dsfs_pkg::CMD_OUT)
        begin
            out_action_reg <= code_reg;
            out_cv_reg <= cand_v_reg;
            out_ck_reg <= cand_v_reg & cand_k_reg;
            out_cg_reg <= cand_v_reg ? cand_g_reg : '0;
            out_av_reg <= act_v_reg;
            out_ak_reg <= act_v_reg & act_k_reg;
            out_ag_reg <= act_v_reg ? act_g_reg : '0;
            out_h_reg <= healthy_reg;  out_p_reg <= paused_reg;
            out_t_reg <= term_reg;  out_r_reg <= retire_reg;  out_lf_reg <= lf_reg;
        end
    end

    assign action = out_action_reg;
    assign cand_valid = out_cv_reg;
    assign cand_kind = out_ck_reg;
    assign cand_gen = out_cg_reg;
    assign act_valid = out_av_reg;
    assign act_kind = out_ak_reg;
    assign act_gen = out_ag_reg;
    assign act_healthy = out_h_reg;
    assign is_paused = out_p_reg;
    assign is_terminal = out_t_reg;
    assign retire_busy = out_r_reg;
    assign fail_code = out_lf_reg;
endmodule

// File: design/dual_source_failover_selector_core.sv
`timescale 1ns / 1ps
// Failover selector between capture sources A and B. Each accepted event
// transaction yields exactly one result transaction carrying the chosen action
// and a snapshot of the active and candidate generations and status flags.
// An event passes through accept, decide and output when no candidate start
// is considered; through accept, decide, check and output when the start check
// stops it (nothing pending, blocked by pause, terminal, retirement or a live
// candidate, or the failure streak at its limit); and through accept, decide,
// check, prune, select and output when it goes on to the attempt window, where
// the prune state drops, one entry at a time, the attempt timestamps (0..8) that
// have aged out of the 60 s window. One event is in flight at a time; a finished
// result is held in an output register until taken, so a stalled receiver holds
// off the next result, and the next event is accepted in the cycle after that
// register is loaded.
module dual_source_failover_selector_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [dsfs_pkg::MS_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [3:0]                    mode,
    input  logic [dsfs_pkg::TIME_W-1:0]   now_ms,
    input  logic                          origin_kind,
    input  logic [dsfs_pkg::GEN_W-1:0]    origin_generation,
    input  logic                          force_valid,
    input  logic                          force_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    action,
    output logic                          cand_valid,
    output logic                          cand_kind,
    output logic [dsfs_pkg::GEN_W-1:0]    cand_gen,
    output logic                          act_valid,
    output logic                          act_kind,
    output logic [dsfs_pkg::GEN_W-1:0]    act_gen,
    output logic                          act_healthy,
    output logic                          is_paused,
    output logic                          is_terminal,
    output logic                          retire_busy,
    output logic [2:0]                    fail_code
);
    dsfs_pkg::cmd_t    cmd;
    dsfs_pkg::status_t status;

    // sequencer: decide, check, prune, select, hold result
    dsfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // state, config registers, attempt window and result register
    dsfs_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .now_ms            (now_ms),
        .origin_kind       (origin_kind),
        .origin_generation (origin_generation),
        .force_valid       (force_valid),
        .force_kind        (force_kind),
        .action            (action),
        .cand_valid        (cand_valid),
        .cand_kind         (cand_kind),
        .cand_gen          (cand_gen),
        .act_valid         (act_valid),
        .act_kind          (act_kind),
        .act_gen           (act_gen),
        .act_healthy       (act_healthy),
        .is_paused         (is_paused),
        .is_terminal       (is_terminal),
        .retire_busy       (retire_busy),
        .fail_code         (fail_code)
    );
endmodule
